[sv/spi_rfm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_rfm_pkg
// shared types, codes and constants of the burst register-access frame master
// ----------------------------------------------------------------------------
package spi_rfm_pkg;

  localparam logic [24:0] ADDRESS_LIMIT = 25'h1FF_FFFF;
  localparam logic [7:0]  MAX_BURST     = 8'd128;

  localparam logic [1:0] FUNC_BEGIN = 2'd0;
  localparam logic [1:0] FUNC_WDATA = 2'd1;
  localparam logic [1:0] FUNC_RXBYTE = 2'd2;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ARG = 2'd1;
  localparam logic [1:0] ST_BAD_HDR = 2'd2;
  localparam logic [1:0] ST_BAD_SUM = 2'd3;

  localparam logic [7:0] HDR0     = 8'h4D;
  localparam logic [7:0] HDR1     = 8'hD3;
  localparam logic [7:0] ACK0     = 8'hA0;
  localparam logic [7:0] ACK1     = 8'hA1;
  localparam logic [7:0] OP_WRITE = 8'h80;
  localparam logic [7:0] OP_READ  = 8'h00;

  localparam int QDEPTH = 9;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]  func;
    logic [24:0] target_address;
    logic        is_write;
    logic [7:0]  burst_count;
    logic [31:0] write_word;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  tx_byte;
    logic [31:0] read_word;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    out_item_t [QDEPTH-1:0] items;
    logic [QCNT_W-1:0]      cnt;
  } batch_t;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_REPLY1 = 6'b000010,
    PH_REPLY2 = 6'b000100,
    PH_WDATA  = 6'b001000,
    PH_RDATA  = 6'b010000,
    PH_RSUM   = 6'b100000
  } phase_t;

  function automatic out_item_t mk_tx(input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.out_kind = KIND_TX;
    r.tx_byte = b;
    return r;
  endfunction

  function automatic out_item_t mk_done(input logic [1:0] st);
    out_item_t r;
    r = '0;
    r.out_kind = KIND_DONE;
    r.status = st;
    return r;
  endfunction

  function automatic out_item_t mk_word(input logic [31:0] w);
    out_item_t r;
    r = '0;
    r.out_kind = KIND_WORD;
    r.read_word = w;
    return r;
  endfunction

endpackage

[sv/spi_rfm_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_rfm_engine
// frame state and per-item result generation, one item per cycle while accept is high
// ----------------------------------------------------------------------------
module spi_rfm_engine #(
  parameter logic [24:0] ADDRESS_LIMIT = spi_rfm_pkg::ADDRESS_LIMIT,
  parameter logic [7:0]  MAX_BURST     = spi_rfm_pkg::MAX_BURST
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  spi_rfm_pkg::in_item_t item,
  output spi_rfm_pkg::batch_t   batch
);

  spi_rfm_pkg::phase_t phase_r, phase_nxt;
  logic        write_mode_r, write_mode_nxt;
  logic [23:0] held_address_r, held_address_nxt;
  logic [7:0]  words_left_r, words_left_nxt;
  logic [1:0]  byte_position_r, byte_position_nxt;
  logic [31:0] frame_sum_r, frame_sum_nxt;
  logic [31:0] word_assembly_r, word_assembly_nxt;
  logic [7:0]  first_reply_r, first_reply_nxt;

  logic [25:0] span;
  logic        args_ok;
  logic [31:0] hdr_sum;
  logic [31:0] wsum;
  logic [31:0] shifted;
  logic [7:0]  wl_dec;
  logic [7:0]  op_byte;
  logic [spi_rfm_pkg::QCNT_W-1:0] n;
  spi_rfm_pkg::out_item_t [spi_rfm_pkg::QDEPTH-1:0] res;

  assign span    = {1'b0, item.target_address} + {18'd0, item.burst_count};
  assign args_ok = (item.target_address < ADDRESS_LIMIT)
                && (item.burst_count <= MAX_BURST)
                && (span <= {1'b0, ADDRESS_LIMIT});
  assign op_byte = write_mode_r ? spi_rfm_pkg::OP_WRITE : spi_rfm_pkg::OP_READ;
  assign hdr_sum = 32'(spi_rfm_pkg::HDR0) + 32'(spi_rfm_pkg::HDR1)
                 + 32'(held_address_r[23:16]) + 32'(held_address_r[15:8])
                 + 32'(held_address_r[7:0]) + 32'(op_byte) + 32'(words_left_r);
  assign wsum    = frame_sum_r + 32'(item.write_word[31:24]) + 32'(item.write_word[23:16])
                 + 32'(item.write_word[15:8]) + 32'(item.write_word[7:0]);
  assign shifted = {word_assembly_r[23:0], item.rx_byte};
  assign wl_dec  = words_left_r - 8'd1;

  always_comb begin
    phase_nxt         = phase_r;
    write_mode_nxt    = write_mode_r;
    held_address_nxt  = held_address_r;
    words_left_nxt    = words_left_r;
    byte_position_nxt = byte_position_r;
    frame_sum_nxt     = frame_sum_r;
    word_assembly_nxt = word_assembly_r;
    first_reply_nxt   = first_reply_r;
    res = '0;
    n   = '0;
    if (accept) begin
      unique case (phase_r)
        spi_rfm_pkg::PH_IDLE: begin
          if (item.func == spi_rfm_pkg::FUNC_BEGIN) begin
            if (args_ok) begin
              write_mode_nxt    = item.is_write;
              held_address_nxt  = item.target_address[23:0];
              words_left_nxt    = item.burst_count;
              byte_position_nxt = '0;
              word_assembly_nxt = '0;
              frame_sum_nxt     = '0;
              phase_nxt         = spi_rfm_pkg::PH_REPLY1;
              res[0] = spi_rfm_pkg::mk_tx(spi_rfm_pkg::HDR0);
            end else begin
              res[0] = spi_rfm_pkg::mk_done(spi_rfm_pkg::ST_BAD_ARG);
            end
            n = spi_rfm_pkg::QCNT_W'(1);
          end
        end
        spi_rfm_pkg::PH_REPLY1: begin
          if (item.func == spi_rfm_pkg::FUNC_RXBYTE) begin
            first_reply_nxt = item.rx_byte;
            phase_nxt       = spi_rfm_pkg::PH_REPLY2;
            res[0] = spi_rfm_pkg::mk_tx(spi_rfm_pkg::HDR1);
            n = spi_rfm_pkg::QCNT_W'(1);
          end
        end
        spi_rfm_pkg::PH_REPLY2: begin
          if (item.func == spi_rfm_pkg::FUNC_RXBYTE) begin
            if (first_reply_r == spi_rfm_pkg::ACK0 && item.rx_byte == spi_rfm_pkg::ACK1) begin
              frame_sum_nxt = hdr_sum;
              res[0] = spi_rfm_pkg::mk_tx(8'h00);
              res[1] = spi_rfm_pkg::mk_tx(held_address_r[23:16]);
              res[2] = spi_rfm_pkg::mk_tx(held_address_r[15:8]);
              res[3] = spi_rfm_pkg::mk_tx(held_address_r[7:0]);
              res[4] = spi_rfm_pkg::mk_tx(op_byte);
              res[5] = spi_rfm_pkg::mk_tx(words_left_r);
              n = spi_rfm_pkg::QCNT_W'(6);
              byte_position_nxt = '0;
              word_assembly_nxt = '0;
              if (write_mode_r) begin
                phase_nxt = spi_rfm_pkg::PH_WDATA;
              end else if (words_left_r != 8'd0) begin
                phase_nxt = spi_rfm_pkg::PH_RDATA;
              end else begin
                phase_nxt = spi_rfm_pkg::PH_RSUM;
              end
            end else begin
              phase_nxt = spi_rfm_pkg::PH_IDLE;
              res[0] = spi_rfm_pkg::mk_done(spi_rfm_pkg::ST_BAD_HDR);
              n = spi_rfm_pkg::QCNT_W'(1);
            end
          end
        end
        spi_rfm_pkg::PH_WDATA: begin
          if (item.func == spi_rfm_pkg::FUNC_WDATA) begin
            if (words_left_r != 8'd0) begin
              res[0] = spi_rfm_pkg::mk_tx(item.write_word[31:24]);
              res[1] = spi_rfm_pkg::mk_tx(item.write_word[23:16]);
              res[2] = spi_rfm_pkg::mk_tx(item.write_word[15:8]);
              res[3] = spi_rfm_pkg::mk_tx(item.write_word[7:0]);
              frame_sum_nxt  = wsum;
              words_left_nxt = wl_dec;
              if (wl_dec == 8'd0) begin
                res[4] = spi_rfm_pkg::mk_tx(wsum[31:24]);
                res[5] = spi_rfm_pkg::mk_tx(wsum[23:16]);
                res[6] = spi_rfm_pkg::mk_tx(wsum[15:8]);
                res[7] = spi_rfm_pkg::mk_tx(wsum[7:0]);
                res[8] = spi_rfm_pkg::mk_done(spi_rfm_pkg::ST_OK);
                n = spi_rfm_pkg::QCNT_W'(9);
                phase_nxt = spi_rfm_pkg::PH_IDLE;
              end else begin
                n = spi_rfm_pkg::QCNT_W'(4);
              end
            end else begin
              res[0] = spi_rfm_pkg::mk_tx(frame_sum_r[31:24]);
              res[1] = spi_rfm_pkg::mk_tx(frame_sum_r[23:16]);
              res[2] = spi_rfm_pkg::mk_tx(frame_sum_r[15:8]);
              res[3] = spi_rfm_pkg::mk_tx(frame_sum_r[7:0]);
              res[4] = spi_rfm_pkg::mk_done(spi_rfm_pkg::ST_OK);
              n = spi_rfm_pkg::QCNT_W'(5);
              phase_nxt = spi_rfm_pkg::PH_IDLE;
            end
          end
        end
        spi_rfm_pkg::PH_RDATA: begin
          if (item.func == spi_rfm_pkg::FUNC_RXBYTE) begin
            frame_sum_nxt = frame_sum_r + 32'(item.rx_byte);
            if (byte_position_r == 2'd3) begin
              byte_position_nxt = '0;
              res[0] = spi_rfm_pkg::mk_word(shifted);
              n = spi_rfm_pkg::QCNT_W'(1);
              word_assembly_nxt = '0;
              words_left_nxt    = wl_dec;
              if (wl_dec == 8'd0) begin
                phase_nxt = spi_rfm_pkg::PH_RSUM;
              end
            end else begin
              word_assembly_nxt = shifted;
              byte_position_nxt = byte_position_r + 2'd1;
            end
          end
        end
        spi_rfm_pkg::PH_RSUM: begin
          if (item.func == spi_rfm_pkg::FUNC_RXBYTE) begin
            if (byte_position_r == 2'd3) begin
              byte_position_nxt = '0;
              word_assembly_nxt = '0;
              phase_nxt         = spi_rfm_pkg::PH_IDLE;
              res[0] = spi_rfm_pkg::mk_done(shifted == frame_sum_r ?
                                            spi_rfm_pkg::ST_OK : spi_rfm_pkg::ST_BAD_SUM);
              n = spi_rfm_pkg::QCNT_W'(1);
            end else begin
              word_assembly_nxt = shifted;
              byte_position_nxt = byte_position_r + 2'd1;
            end
          end
        end
        default: begin
          phase_nxt = spi_rfm_pkg::PH_IDLE;
        end
      endcase
    end
    for (int i = 0; i < spi_rfm_pkg::QDEPTH; i++) begin
      res[i].last = (spi_rfm_pkg::QCNT_W'(i) == n - spi_rfm_pkg::QCNT_W'(1));
    end
  end

  assign batch.items = res;
  assign batch.cnt   = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= spi_rfm_pkg::PH_IDLE;
      write_mode_r    <= 1'b0;
      held_address_r  <= '0;
      words_left_r    <= '0;
      byte_position_r <= '0;
      frame_sum_r     <= '0;
      word_assembly_r <= '0;
      first_reply_r   <= '0;
    end else begin
      phase_r         <= phase_nxt;
      write_mode_r    <= write_mode_nxt;
      held_address_r  <= held_address_nxt;
      words_left_r    <= words_left_nxt;
      byte_position_r <= byte_position_nxt;
      frame_sum_r     <= frame_sum_nxt;
      word_assembly_r <= word_assembly_nxt;
      first_reply_r   <= first_reply_nxt;
    end
  end

endmodule

[sv/spi_rfm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_rfm_queue
// result register: holds one item's results and shifts them out in order
// ----------------------------------------------------------------------------
module spi_rfm_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  spi_rfm_pkg::batch_t    batch,
  output logic                   space,
  output logic                   out_valid,
  input  logic                   out_ready,
  output spi_rfm_pkg::out_item_t out_payload
);

  spi_rfm_pkg::out_item_t [spi_rfm_pkg::QDEPTH-1:0] items_r, items_nxt;
  logic [spi_rfm_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign out_valid   = (cnt_r != '0);
  assign out_payload = items_r[0];
  assign space       = (cnt_r == '0)
                    || (cnt_r == spi_rfm_pkg::QCNT_W'(1) && out_ready);

  always_comb begin
    items_nxt = items_r;
    cnt_nxt   = cnt_r;
    if (batch.cnt != '0) begin
      items_nxt = batch.items;
      cnt_nxt   = batch.cnt;
    end else if (out_valid && out_ready) begin
      for (int i = 0; i < spi_rfm_pkg::QDEPTH - 1; i++) begin
        items_nxt[i] = items_r[i+1];
      end
      cnt_nxt = cnt_r - spi_rfm_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    items_r <= items_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[sv/spi_register_frame_master_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_register_frame_master_top
// master side of a burst register-access frame over spi
// ----------------------------------------------------------------------------
//  channel | ports                          | carries
//  input   | in_valid, in_ready, in_payload | begin, write word, received byte
//  result  | out_valid, out_ready, out_payload | tx byte, read word, finish
//
//  an item is taken the cycle it arrives when no results are pending or the
//  last pending one leaves that cycle; its results (up to nine) appear from
//  the next cycle, one per out handshake, so with out_ready high throughput is one item a cycle
//  for single-result items and one item per result otherwise
//  reset is synchronous, clears the frame state and drops any pending results
//  out_ready low stalls the result register and holds off in_ready
// ----------------------------------------------------------------------------
module spi_register_frame_master_top #(
  parameter logic [24:0] ADDRESS_LIMIT = spi_rfm_pkg::ADDRESS_LIMIT,
  parameter logic [7:0]  MAX_BURST     = spi_rfm_pkg::MAX_BURST
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  spi_rfm_pkg::in_item_t  in_payload,
  output logic                   out_valid,
  input  logic                   out_ready,
  output spi_rfm_pkg::out_item_t out_payload
);

  spi_rfm_pkg::batch_t batch;
  logic accept;

  assign accept = in_valid && in_ready;

  spi_rfm_engine #(
    .ADDRESS_LIMIT (ADDRESS_LIMIT),
    .MAX_BURST     (MAX_BURST)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_payload),
    .batch  (batch)
  );

  spi_rfm_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .batch       (batch),
    .space       (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

endmodule

[sv/spi_rfm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_rfm_checker
// port-level checks of the frame master
// ----------------------------------------------------------------------------
module spi_rfm_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input spi_rfm_pkg::in_item_t  in_payload,
  input logic                   out_valid,
  input logic                   out_ready,
  input spi_rfm_pkg::out_item_t out_payload
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  // reset drops pending results
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.out_kind == spi_rfm_pkg::KIND_DONE |-> out_payload.last)
    else $error("finish item not marked last");

  a_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.out_kind != spi_rfm_pkg::KIND_WORD
      |-> out_payload.read_word == 32'd0)
    else $error("stray read word");

  // no new item while more than one result still waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.last |-> !in_ready)
    else $error("item taken with results still pending");

endmodule

bind spi_register_frame_master_top spi_rfm_checker u_checker (.*);
